// ===== rtl/range_min_index_segment_tree_unit_assert.svh =====
// Assertion macros for the range-minimum segment tree unit
`ifndef RANGE_MIN_INDEX_SEGMENT_TREE_UNIT_ASSERT_SVH
`define RANGE_MIN_INDEX_SEGMENT_TREE_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RMST_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define RMST_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rmst_pkg.sv =====
// Shared item types and operation codes for the range-minimum segment tree unit
package rmst_pkg;

  localparam int OP_W  = 2;
  localparam int POS_W = 10;
  localparam int VAL_W = 16;
  localparam int CNT_W = 11;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] range_end;
    logic [VAL_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] min_position;
    logic [VAL_W-1:0] min_value;
    logic             found;
  } out_item_t;

endpackage

// ===== rtl/range_min_index_segment_tree_unit.sv =====
// Range-minimum unit: value store, segment tree of positions, rightmost-minimum queries
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+------------------------------
//   cfg     | in        | cfg_wr_en         | cfg_wr_data (element count)
//   in      | in        | in_valid/in_stall | in_item (op, range, value)
//   out     | out       | out_valid/out_stall | out_item (position, value, found)
//
// Load: a single value-store write. Build: a post-order walk that does one stack
//   step per cycle and waits on the value-store read at each leaf.
// Query: a walk over the tree nodes, with two reads per covering node (tree read,
//   then value read); up to about 4*log2(count) nodes are visited.
// Reset clears control only; both stores start unknown and need no clearing pass.
// A result waits in the output register under out_stall while the next item is
//   taken; a query that finishes behind it holds until the register frees.
`include "range_min_index_segment_tree_unit_assert.svh"

module range_min_index_segment_tree_unit
  import rmst_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024,
  parameter int VALUE_BITS   = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item
);

  localparam int IW         = $clog2(MAX_ELEMENTS);
  localparam int CW         = IW + 1;
  localparam int NW         = IW + 1;
  localparam int TREE_DEPTH = 2 ** NW;
  localparam int BW         = (CW > CNT_W) ? CW : CNT_W;
  localparam int SDEPTH     = IW + 1;
  localparam int SIW        = $clog2(SDEPTH);
  localparam int SPW        = $clog2(SDEPTH + 1);

  typedef struct packed {
    logic [IW-1:0]         lo;
    logic [IW-1:0]         hi;
    logic [NW-1:0]         node;
    logic                  left_done;
    logic [IW-1:0]         left_pos;
    logic [VALUE_BITS-1:0] left_val;
  } frame_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BDESC,
    S_BLEAF,
    S_BRET,
    S_QEVAL,
    S_QTREE,
    S_QVAL,
    S_QDONE
  } state_t;

  state_t                state_r, state_nxt;
  frame_t                stack_r [SDEPTH];
  frame_t                stack_nxt [SDEPTH];
  logic [SPW-1:0]        sp_r, sp_nxt;
  logic [IW-1:0]         cur_lo_r, cur_lo_nxt;
  logic [IW-1:0]         cur_hi_r, cur_hi_nxt;
  logic [NW-1:0]         cur_node_r, cur_node_nxt;
  logic [BW-1:0]         qs_r, qs_nxt;
  logic [BW-1:0]         qe_r, qe_nxt;
  logic                  acc_found_r, acc_found_nxt;
  logic [IW-1:0]         acc_pos_r, acc_pos_nxt;
  logic [VALUE_BITS-1:0] acc_val_r, acc_val_nxt;
  logic [IW-1:0]         cand_pos_r, cand_pos_nxt;
  logic [IW-1:0]         ret_pos_r, ret_pos_nxt;
  logic [VALUE_BITS-1:0] ret_val_r, ret_val_nxt;
  logic                  built_r, built_nxt;
  logic [CW-1:0]         built_cnt_r, built_cnt_nxt;
  logic [CNT_W-1:0]      element_count_r, element_count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r, out_item_nxt;

  logic                  in_accept;
  logic [IW:0]           cur_sum;
  logic [IW-1:0]         cur_mid;
  logic [NW-1:0]         lnode;
  logic [NW-1:0]         rnode;
  logic [SPW-1:0]        sp_dec;
  logic [SIW-1:0]        top_idx;
  logic [SIW-1:0]        push_idx;
  frame_t                top;
  logic [NW-1:0]         top_rnode;
  logic                  covered;
  logic                  disjoint;
  logic [CW-1:0]         eff_cnt;
  logic                  pos_ok;
  logic                  pick_left;

  logic                  tree_we;
  logic [NW-1:0]         tree_waddr;
  logic [IW-1:0]         tree_wdata;
  logic [NW-1:0]         tree_raddr;
  logic [IW-1:0]         tree_rdata;
  logic                  val_we;
  logic [IW-1:0]         val_waddr;
  logic [VALUE_BITS-1:0] val_wdata;
  logic [IW-1:0]         val_raddr;
  logic [VALUE_BITS-1:0] val_rdata;

  rmst_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ELEMENTS)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (val_we),
    .wr_addr (val_waddr),
    .wr_data (val_wdata),
    .rd_addr (val_raddr),
    .rd_data (val_rdata)
  );

  rmst_ram #(
    .WIDTH (IW),
    .DEPTH (TREE_DEPTH)
  ) u_tree_ram (
    .clk     (clk),
    .wr_en   (tree_we),
    .wr_addr (tree_waddr),
    .wr_data (tree_wdata),
    .rd_addr (tree_raddr),
    .rd_data (tree_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign cur_sum   = {1'b0, cur_lo_r} + {1'b0, cur_hi_r};
  assign cur_mid   = cur_sum[IW:1];
  assign lnode     = {cur_node_r[NW-2:0], 1'b1};
  assign rnode     = lnode + 1'b1;
  assign sp_dec    = sp_r - 1'b1;
  assign top_idx   = sp_dec[SIW-1:0];
  assign push_idx  = sp_r[SIW-1:0];
  assign top       = stack_r[top_idx];
  assign top_rnode = {top.node[NW-2:0], 1'b1} + 1'b1;
  assign covered   = (qs_r <= BW'(cur_lo_r)) && (qe_r >= BW'(cur_hi_r));
  assign disjoint  = (BW'(cur_hi_r) < qs_r) || (BW'(cur_lo_r) > qe_r);
  assign pos_ok    = BW'(in_item.position) < BW'(MAX_ELEMENTS);
  assign pick_left = top.left_val < ret_val_r;

  assign val_we    = in_accept && (in_item.operation == OP_LOAD) && pos_ok;
  assign val_waddr = IW'(in_item.position);
  assign val_wdata = VALUE_BITS'(in_item.element_value);

  always_comb begin
    if (element_count_r == '0) begin
      eff_cnt = CW'(1);
    end else if (BW'(element_count_r) > BW'(MAX_ELEMENTS)) begin
      eff_cnt = CW'(MAX_ELEMENTS);
    end else begin
      eff_cnt = CW'(element_count_r);
    end
  end

  always_comb begin
    state_nxt         = state_r;
    stack_nxt         = stack_r;
    sp_nxt            = sp_r;
    cur_lo_nxt        = cur_lo_r;
    cur_hi_nxt        = cur_hi_r;
    cur_node_nxt      = cur_node_r;
    qs_nxt            = qs_r;
    qe_nxt            = qe_r;
    acc_found_nxt     = acc_found_r;
    acc_pos_nxt       = acc_pos_r;
    acc_val_nxt       = acc_val_r;
    cand_pos_nxt      = cand_pos_r;
    ret_pos_nxt       = ret_pos_r;
    ret_val_nxt       = ret_val_r;
    built_nxt         = built_r;
    built_cnt_nxt     = built_cnt_r;
    element_count_nxt = cfg_wr_en ? cfg_wr_data : element_count_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_item_nxt      = out_item_r;
    tree_we           = 1'b0;
    tree_waddr        = cur_node_r;
    tree_wdata        = cur_lo_r;
    tree_raddr        = cur_node_r;
    val_raddr         = cur_lo_r;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          case (in_item.operation)
            OP_BUILD: begin
              built_cnt_nxt = eff_cnt;
              cur_lo_nxt    = '0;
              cur_hi_nxt    = IW'(eff_cnt - 1'b1);
              cur_node_nxt  = '0;
              sp_nxt        = '0;
              state_nxt     = S_BDESC;
            end
            OP_QUERY: begin
              qs_nxt        = BW'(in_item.position);
              qe_nxt        = BW'(in_item.range_end);
              acc_found_nxt = 1'b0;
              cur_lo_nxt    = '0;
              cur_hi_nxt    = IW'(built_cnt_r - 1'b1);
              cur_node_nxt  = '0;
              sp_nxt        = '0;
              state_nxt     = built_r ? S_QEVAL : S_QDONE;
            end
            default: ;
          endcase
        end
      end

      S_BDESC: begin
        if (cur_lo_r == cur_hi_r) begin
          state_nxt = S_BLEAF;
        end else begin
          stack_nxt[push_idx].lo        = cur_mid + 1'b1;
          stack_nxt[push_idx].hi        = cur_hi_r;
          stack_nxt[push_idx].node      = cur_node_r;
          stack_nxt[push_idx].left_done = 1'b0;
          sp_nxt       = sp_r + 1'b1;
          cur_hi_nxt   = cur_mid;
          cur_node_nxt = lnode;
        end
      end

      S_BLEAF: begin
        tree_we     = 1'b1;
        ret_pos_nxt = cur_lo_r;
        ret_val_nxt = val_rdata;
        state_nxt   = S_BRET;
      end

      S_BRET: begin
        if (sp_r == '0) begin
          built_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (!top.left_done) begin
          stack_nxt[top_idx].left_done = 1'b1;
          stack_nxt[top_idx].left_pos  = ret_pos_r;
          stack_nxt[top_idx].left_val  = ret_val_r;
          cur_lo_nxt   = top.lo;
          cur_hi_nxt   = top.hi;
          cur_node_nxt = top_rnode;
          state_nxt    = S_BDESC;
        end else begin
          tree_we     = 1'b1;
          tree_waddr  = top.node;
          tree_wdata  = pick_left ? top.left_pos : ret_pos_r;
          ret_pos_nxt = pick_left ? top.left_pos : ret_pos_r;
          ret_val_nxt = pick_left ? top.left_val : ret_val_r;
          sp_nxt      = sp_dec;
        end
      end

      S_QEVAL: begin
        if (covered) begin
          state_nxt = S_QTREE;
        end else if (disjoint) begin
          if (sp_r == '0) begin
            state_nxt = S_QDONE;
          end else begin
            cur_lo_nxt   = top.lo;
            cur_hi_nxt   = top.hi;
            cur_node_nxt = top.node;
            sp_nxt       = sp_dec;
          end
        end else begin
          stack_nxt[push_idx].lo   = cur_mid + 1'b1;
          stack_nxt[push_idx].hi   = cur_hi_r;
          stack_nxt[push_idx].node = rnode;
          sp_nxt       = sp_r + 1'b1;
          cur_hi_nxt   = cur_mid;
          cur_node_nxt = lnode;
        end
      end

      S_QTREE: begin
        val_raddr    = tree_rdata;
        cand_pos_nxt = tree_rdata;
        state_nxt    = S_QVAL;
      end

      S_QVAL: begin
        if (!acc_found_r || !(acc_val_r < val_rdata)) begin
          acc_pos_nxt = cand_pos_r;
          acc_val_nxt = val_rdata;
        end
        acc_found_nxt = 1'b1;
        if (sp_r == '0) begin
          state_nxt = S_QDONE;
        end else begin
          cur_lo_nxt   = top.lo;
          cur_hi_nxt   = top.hi;
          cur_node_nxt = top.node;
          sp_nxt       = sp_dec;
          state_nxt    = S_QEVAL;
        end
      end

      S_QDONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.found        = acc_found_r;
          out_item_nxt.min_position = acc_found_r ? POS_W'(acc_pos_r) : '0;
          out_item_nxt.min_value    = acc_found_r ? VAL_W'(acc_val_r) : '0;
          state_nxt                 = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      sp_r            <= '0;
      acc_found_r     <= 1'b0;
      built_r         <= 1'b0;
      built_cnt_r     <= CW'(1);
      element_count_r <= CNT_W'(1);
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      sp_r            <= sp_nxt;
      acc_found_r     <= acc_found_nxt;
      built_r         <= built_nxt;
      built_cnt_r     <= built_cnt_nxt;
      element_count_r <= element_count_nxt;
      out_valid_r     <= out_valid_nxt;
    end
    stack_r    <= stack_nxt;
    cur_lo_r   <= cur_lo_nxt;
    cur_hi_r   <= cur_hi_nxt;
    cur_node_r <= cur_node_nxt;
    qs_r       <= qs_nxt;
    qe_r       <= qe_nxt;
    acc_pos_r  <= acc_pos_nxt;
    acc_val_r  <= acc_val_nxt;
    cand_pos_r <= cand_pos_nxt;
    ret_pos_r  <= ret_pos_nxt;
    ret_val_r  <= ret_val_nxt;
    out_item_r <= out_item_nxt;
  end

  `RMST_ASSERT_NOW(a_idle_stack_empty, state_r == S_IDLE, sp_r == '0, "stack not empty at idle")
  `RMST_ASSERT_NOW(a_tree_write_in_build, tree_we, state_r == S_BLEAF || state_r == S_BRET,
                   "tree written outside build")
  `RMST_ASSERT_NOW(a_result_from_query, $rose(out_valid_r), $past(state_r == S_QDONE),
                   "result not from a finished query")
  `RMST_ASSERT_NOW(a_built_after_walk, $rose(built_r), $past(state_r == S_BRET && sp_r == '0),
                   "tree marked built before walk ended")

endmodule

// ===== rtl/rmst_ram.sv =====
// Generic single-port-write RAM with one registered read port
module rmst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== tb/sv/range_min_index_segment_tree_unit_tb.sv =====
// Testbench for the range-minimum segment tree unit: random items against a scoreboard
module range_min_index_segment_tree_unit_tb
  import rmst_pkg::*;
();

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int SPAN_MAX   = 1024;
  localparam int HOLD_LONG  = 600;
  localparam int IDLE_LIMIT = 40000;

  class rmq_scoreboard;
    logic [VAL_W-1:0] values[SPAN_MAX];
    logic [POS_W-1:0] nodes[4*SPAN_MAX];
    int unsigned count_reg;
    int unsigned tree_span;
    bit tree_ready;
    out_item_t pending[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      count_reg  = 1;
      tree_span  = 1;
      tree_ready = 1'b0;
      errors     = 0;
      checked    = 0;
    endfunction

    function void set_count(logic [CNT_W-1:0] v);
      count_reg = 32'(v);
    endfunction

    function logic [POS_W-1:0] rightmost_min(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
      return (values[a] < values[b]) ? a : b;
    endfunction

    function void build_span(int unsigned lo, int unsigned hi, int unsigned node);
      int unsigned mid;
      if (lo == hi) begin
        nodes[node] = lo[POS_W-1:0];
        return;
      end
      mid = (lo + hi) / 2;
      build_span(lo, mid, 2 * node + 1);
      build_span(mid + 1, hi, 2 * node + 2);
      nodes[node] = rightmost_min(nodes[2 * node + 1], nodes[2 * node + 2]);
    endfunction

    function bit query_span(int unsigned lo, int unsigned hi, int unsigned qs,
                            int unsigned qe, int unsigned node,
                            output logic [POS_W-1:0] where_pos);
      bit hit_l;
      bit hit_r;
      logic [POS_W-1:0] pl;
      logic [POS_W-1:0] pr;
      int unsigned mid;
      where_pos = '0;
      if (qs <= lo && qe >= hi) begin
        where_pos = nodes[node];
        return 1'b1;
      end
      if (hi < qs || lo > qe) return 1'b0;
      mid = (lo + hi) / 2;
      hit_l = query_span(lo, mid, qs, qe, 2 * node + 1, pl);
      hit_r = query_span(mid + 1, hi, qs, qe, 2 * node + 2, pr);
      if (!hit_l) begin
        where_pos = pr;
        return hit_r;
      end
      if (!hit_r) begin
        where_pos = pl;
        return 1'b1;
      end
      where_pos = rightmost_min(pl, pr);
      return 1'b1;
    endfunction

    function void note_input(in_item_t it);
      out_item_t exp;
      logic [POS_W-1:0] where_pos;
      case (it.operation)
        OP_LOAD: begin
          values[it.position] = it.element_value;
        end
        OP_BUILD: begin
          if (count_reg == 0) tree_span = 1;
          else if (count_reg > SPAN_MAX) tree_span = SPAN_MAX;
          else tree_span = count_reg;
          build_span(0, tree_span - 1, 0);
          tree_ready = 1'b1;
        end
        OP_QUERY: begin
          exp = '0;
          if (tree_ready &&
              query_span(0, tree_span - 1, 32'(it.position), 32'(it.range_end), 0,
                         where_pos)) begin
            exp.min_position = where_pos;
            exp.min_value    = values[where_pos];
            exp.found        = 1'b1;
          end
          pending = {pending, exp};
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending.size() == 0) begin
        $error("result with no pending query: min_position %0d min_value %0d found %0b",
               got.min_position, got.min_value, got.found);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.min_position !== exp.min_position) begin
        $error("min_position: expected %0d, got %0d", exp.min_position, got.min_position);
        errors++;
      end
      if (got.min_value !== exp.min_value) begin
        $error("min_value: expected %0d, got %0d", exp.min_value, got.min_value);
        errors++;
      end
      if (got.found !== exp.found) begin
        $error("found: expected %0b, got %0b", exp.found, got.found);
        errors++;
      end
    endfunction

    function void flag_leftovers();
      if (pending.size() != 0) begin
        $error("%0d queries never answered", pending.size());
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_item;

  range_min_index_segment_tree_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  rmq_scoreboard sb = new();

  bit          loaded[SPAN_MAX];
  int unsigned cur_span = 1;
  int unsigned built_span = 1;
  int unsigned dense_left = 0;
  bit          hold_request = 1'b0;
  int unsigned loads_sent = 0;
  int unsigned builds_sent = 0;
  int unsigned queries_sent = 0;
  int unsigned unused_sent = 0;
  int unsigned idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (dense_left > 0) begin
      dense_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) dense_left = $urandom_range(10, 40);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 100);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return VAL_W'($urandom_range(0, 3));
    if (r == 3) return '1;
    return VAL_W'($urandom_range(0, 65535));
  endfunction

  task automatic send(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                      logic [POS_W-1:0] rend, logic [VAL_W-1:0] val);
    in_item_t it;
    int unsigned gap;
    it.operation     = op;
    it.position      = pos;
    it.range_end     = rend;
    it.element_value = val;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    case (op)
      OP_LOAD: begin
        loaded[pos] = 1'b1;
        loads_sent++;
      end
      OP_BUILD: builds_sent++;
      OP_QUERY: queries_sent++;
      default: unused_sent++;
    endcase
  endtask

  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (5 * built_span + 64) @(posedge clk);
  endtask

  task automatic write_count(logic [CNT_W-1:0] v);
    settle_block();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.set_count(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_span = (v == '0) ? 1 : (32'(v) > SPAN_MAX) ? SPAN_MAX : 32'(v);
  endtask

  task automatic ensure_loaded(int unsigned span);
    for (int p = 0; p < span; p++) begin
      if (!loaded[p]) send(OP_LOAD, POS_W'(p), POS_W'($urandom_range(0, 1023)), pick_value());
    end
  endtask

  task automatic do_build();
    ensure_loaded(cur_span);
    send(OP_BUILD, POS_W'($urandom_range(0, 1023)), POS_W'($urandom_range(0, 1023)),
         VAL_W'($urandom_range(0, 65535)));
    built_span = cur_span;
  endtask

  task automatic issue_query();
    int unsigned r;
    int unsigned a;
    int unsigned b;
    int unsigned lo;
    int unsigned hi;
    r = $urandom_range(0, 19);
    if (r < 12) begin
      a  = $urandom_range(0, built_span - 1);
      b  = $urandom_range(0, built_span - 1);
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
    end else if (r < 14) begin
      lo = $urandom_range(0, built_span - 1);
      hi = $urandom_range(lo, 1023);
    end else if (r < 16) begin
      lo = $urandom_range(0, built_span - 1);
      hi = lo;
    end else if (r < 18) begin
      lo = $urandom_range(0, 1023);
      hi = $urandom_range(0, 1023);
    end else begin
      lo = (built_span < SPAN_MAX) ? $urandom_range(built_span, 1023) : 1023;
      hi = $urandom_range(lo, 1023);
    end
    send(OP_QUERY, POS_W'(lo), POS_W'(hi), VAL_W'($urandom_range(0, 65535)));
  endtask

  task automatic random_step();
    int unsigned r;
    int unsigned pos;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      issue_query();
    end else if (r < 85) begin
      pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                        : $urandom_range(0, cur_span - 1);
      send(OP_LOAD, POS_W'(pos), POS_W'($urandom_range(0, 1023)), pick_value());
    end else if (r < 92) begin
      do_build();
    end else if (r < 97) begin
      send(OP_QUERY, POS_W'($urandom_range(0, 1023)), POS_W'($urandom_range(0, 1023)),
           VAL_W'($urandom_range(0, 65535)));
    end else begin
      send(OP_NONE, POS_W'($urandom_range(0, 1023)), POS_W'($urandom_range(0, 1023)),
           VAL_W'($urandom_range(0, 65535)));
    end
  endtask

  task automatic run_phase(logic [CNT_W-1:0] count, int unsigned steps);
    write_count(count);
    do_build();
    repeat (steps) random_step();
  endtask

  task automatic fill_output();
    hold_request = 1'b1;
    dense_left = 40;
    repeat (40) issue_query();
  endtask

  // receiver: random stall runs, plus one long hold when asked
  initial begin
    int unsigned run_left;
    bit run_stall;
    run_left  = 0;
    run_stall = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_LONG) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_stall = ($urandom_range(0, 2) == 0);
          if (run_stall)
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 3);
          else
            run_left = $urandom_range(1, 40);
        end
        out_stall <= run_stall;
        run_left--;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_item     = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // count 1 from reset: query before build, clipping, empty and reversed ranges
    send(OP_QUERY, 10'd0, 10'd1023, 16'd0);
    send(OP_LOAD, 10'd0, 10'd0, 16'hFFFF);
    send(OP_QUERY, 10'd0, 10'd0, 16'd0);
    send(OP_BUILD, 10'd0, 10'd0, 16'd0);
    built_span = 1;
    send(OP_QUERY, 10'd0, 10'd0, 16'd0);
    send(OP_QUERY, 10'd0, 10'd1023, 16'hFFFF);
    send(OP_QUERY, 10'd1, 10'd1023, 16'd0);
    send(OP_QUERY, 10'd1023, 10'd0, 16'd0);
    send(OP_NONE, 10'd1023, 10'd1023, 16'hFFFF);
    send(OP_LOAD, 10'd0, 10'd1023, 16'd0);
    send(OP_QUERY, 10'd0, 10'd5, 16'd0);

    // count raised without a rebuild, then a tie across both halves
    write_count(11'd2);
    send(OP_LOAD, 10'd1, 10'd0, 16'd0);
    send(OP_QUERY, 10'd0, 10'd1023, 16'd0);
    do_build();
    send(OP_QUERY, 10'd0, 10'd1, 16'd0);
    send(OP_QUERY, 10'd0, 10'd0, 16'd0);
    send(OP_LOAD, 10'd1023, 10'd1023, 16'hFFFF);

    write_count(11'd0);
    do_build();
    send(OP_QUERY, 10'd0, 10'd1023, 16'd0);

    run_phase(11'd3, 25);
    run_phase(11'd5, 25);
    run_phase(11'd16, 25);
    fill_output();
    run_phase(11'd33, 25);
    run_phase(11'd64, 25);
    run_phase(11'd127, 25);
    run_phase(11'd200, 25);
    run_phase(11'd511, 25);
    run_phase(CNT_W'($urandom_range(2, 40)), 25);
    run_phase(11'd7, 25);

    write_count(11'd1024);
    do_build();
    fill_output();
    repeat (40) random_step();
    run_phase(11'd2047, 20);
    run_phase(11'd1025, 20);
    run_phase(11'd1, 20);

    settle_block();
    sb.flag_leftovers();
    $display("Run drove %0d loads, %0d builds, %0d queries and %0d unused-code items",
             loads_sent, builds_sent, queries_sent, unused_sent);
    $display("%0d query results checked over element counts 0 through 2047",
             sb.checked);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== range_min_index_segment_tree_unit.f =====
+incdir+rtl
rtl/rmst_pkg.sv
rtl/rmst_ram.sv
rtl/range_min_index_segment_tree_unit.sv
tb/sv/range_min_index_segment_tree_unit_tb.sv
